[hdl/rce_pkg.sv]
`default_nettype none

package rce_pkg;

    localparam int MAX_CITIES  = 256;
    localparam int DIST_BITS   = 16;
    localparam int CITY_IDX_W  = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int DIST_ADDR_W = 2 * CITY_IDX_W;
    localparam int CITY_W      = 9;
    localparam int VALUE_W     = 16;
    localparam int LOAD_W      = 18;
    localparam int COST_W      = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        OP_DIST   = 2'd0,
        OP_DEMAND = 2'd1,
        OP_GENE   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEPOT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 1'd1;

    typedef logic [CITY_IDX_W-1:0] city_idx_t;

    // Zero-based table index of a one-based city; zero acts as the first city
    // and anything past the table acts as the last one.
    function automatic city_idx_t city_index(input logic [CITY_W-1:0] c);
        logic [31:0] t;
        logic [31:0] r;
        t = 32'(c);
        if (t == 32'd0)
            t = 32'd1;
        else if (t > 32'(MAX_CITIES))
            t = 32'(MAX_CITIES);
        r = t - 32'd1;
        return r[CITY_IDX_W-1:0];
    endfunction

    function automatic logic city_in_range(input logic [CITY_W-1:0] c);
        return (c != '0) && (32'(c) <= 32'(MAX_CITIES));
    endfunction

    typedef struct packed {
        opcode_t            op;
        city_idx_t          a_idx;
        city_idx_t          b_idx;
        logic               a_ok;
        logic               b_ok;
        logic               is_depot;
        logic [VALUE_W-1:0] value;
        logic               last;
    } item_t;

    typedef struct packed {
        logic valid;
        logic use1;
        logic reset_sum;
        logic emit;
    } acc_t;

endpackage

`default_nettype wire

[hdl/rce_if.sv]
`default_nettype none

interface rce_in_if;
    import rce_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [CITY_W-1:0]  city_a;
    logic [CITY_W-1:0]  city_b;
    logic [VALUE_W-1:0] load_value;
    logic               last_gene;

    modport source (output valid, opcode, city_a, city_b, load_value, last_gene,
                    input ready);
    modport sink (input valid, opcode, city_a, city_b, load_value, last_gene,
                  output ready);
endinterface

interface rce_out_if;
    import rce_pkg::*;

    logic              valid;
    logic              ready;
    logic [COST_W-1:0] total_cost;

    modport source (output valid, total_cost, input ready);
    modport sink (input valid, total_cost, output ready);
endinterface

`default_nettype wire

[hdl/vehicle_route_cost_evaluator.sv]
`default_nettype none

// Channel   Dir  Handshake     Payload
// item      in   valid/ready   opcode, city_a, city_b, load_value, last_gene
// result    out  valid/ready   total_cost
// cfg       in   cfg_wr_en     cfg_index, cfg_data (write only)
//
// A load request or an ordinary gene retires as it is issued; a last gene stays
// for a second issue, its return trip, since that needs a second read of the
// distance memory, whose two read ports serve the detour legs of its first issue.
// The cost then passes through the read data and accumulator registers into the
// result register; the return-trip read waits until that register will be free.
// Reset clears the route state; the tables hold garbage until loaded.
// A waiting result stalls only a following last gene, not ordinary genes.

module vehicle_route_cost_evaluator
    import rce_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    rce_in_if.sink                      item,
    rce_out_if.source                   result,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CITY_W-1:0]    depot_reg;
    logic [VALUE_W-1:0]   capacity_reg;
    city_idx_t            dep_idx;
    item_t                s1;
    logic                 s1_valid;
    logic [VALUE_W-1:0]   demand;
    logic                 consume;
    logic                 emit_ok;
    acc_t                 acc;
    logic [DIST_BITS-1:0] rd0, rd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depot_reg    <= CITY_W'(1);
            capacity_reg <= VALUE_W'(100);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEPOT:    depot_reg    <= cfg_data[CITY_W-1:0];
                CFG_CAPACITY: capacity_reg <= cfg_data[VALUE_W-1:0];
            endcase
        end
    end

    assign dep_idx = city_index(depot_reg);

    rce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .consume  (consume),
        .s1       (s1),
        .s1_valid (s1_valid),
        .demand   (demand)
    );

    rce_issue u_issue (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1       (s1),
        .s1_valid (s1_valid),
        .demand   (demand),
        .dep_idx  (dep_idx),
        .capacity (capacity_reg),
        .emit_ok  (emit_ok),
        .consume  (consume),
        .acc      (acc),
        .rd0      (rd0),
        .rd1      (rd1)
    );

    rce_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .rd0     (rd0),
        .rd1     (rd1),
        .emit_ok (emit_ok),
        .result  (result)
    );

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        acc.valid && acc.emit |-> !result.valid || result.ready)
        else $error("final cost arrives while the result register is occupied");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(acc.valid && acc.emit))
        else $error("result raised without a finished route");

    a_emit_single_leg: assert property (@(posedge clk) disable iff (!rst_n)
        acc.valid && acc.emit |-> !acc.use1 && !acc.reset_sum)
        else $error("return trip carries detour or route-start flags");

    a_consume_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        consume |-> s1_valid)
        else $error("request retired from an empty stage");

endmodule

`default_nettype wire

[hdl/rce_front.sv]
`default_nettype none

module rce_front
    import rce_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    rce_in_if.sink            item,
    input  wire logic         consume,
    output item_t             s1,
    output logic              s1_valid,
    output logic [VALUE_W-1:0] demand
);

    logic               s1_valid_reg;
    item_t              s1_reg;
    item_t              in_item;
    logic [VALUE_W-1:0] demand_reg;
    logic [VALUE_W-1:0] dem_mem [0:MAX_CITIES-1];
    logic               accept;

    assign item.ready = !s1_valid_reg || consume;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        in_item.op       = opcode_t'(item.opcode);
        in_item.a_idx    = city_index(item.city_a);
        in_item.b_idx    = city_index(item.city_b);
        in_item.a_ok     = city_in_range(item.city_a);
        in_item.b_ok     = city_in_range(item.city_b);
        in_item.is_depot = (item.city_a == '0);
        in_item.value    = item.load_value;
        in_item.last     = item.last_gene;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Demands are written as the request arrives, so a gene taken later
    // always sees them; the gene's own demand read happens on its arrival.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= in_item;
            if (in_item.op == OP_DEMAND && in_item.a_ok)
            begin
                dem_mem[in_item.a_idx] <= in_item.value;
            end
            if (in_item.op == OP_GENE)
            begin
                demand_reg <= dem_mem[in_item.a_idx];
            end
        end
    end

    assign s1       = s1_reg;
    assign s1_valid = s1_valid_reg;
    assign demand   = demand_reg;

endmodule

`default_nettype wire

[hdl/rce_issue.sv]
`default_nettype none

module rce_issue
    import rce_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire item_t               s1,
    input  wire logic                s1_valid,
    input  wire logic [VALUE_W-1:0]  demand,
    input  wire city_idx_t           dep_idx,
    input  wire logic [VALUE_W-1:0]  capacity,
    input  wire logic                emit_ok,
    output logic                     consume,
    output acc_t                     acc,
    output logic [DIST_BITS-1:0]     rd0,
    output logic [DIST_BITS-1:0]     rd1
);

    typedef enum logic {PH_MAIN, PH_FINAL} phase_t;

    phase_t                 phase_reg;
    city_idx_t              cur_reg, cur_next;
    logic [LOAD_W-1:0]      load_reg, load_next;
    logic                   open_reg;
    acc_t                   acc_reg, acc_next;

    logic [DIST_BITS-1:0]   dist_mem [0:(2**DIST_ADDR_W)-1];
    logic [DIST_BITS-1:0]   rd0_reg, rd1_reg;

    city_idx_t              cur_eff;
    logic [LOAD_W-1:0]      load_eff;
    logic [LOAD_W-1:0]      cap_load;
    logic [LOAD_W:0]        diff;
    logic                   detour;
    logic [DIST_ADDR_W-1:0] addr0, addr1;
    logic                   rd_en, main_fire, final_fire, dist_wr;

    assign cur_eff  = open_reg ? cur_reg : dep_idx;
    assign cap_load = LOAD_W'(capacity);
    assign load_eff = open_reg ? load_reg : cap_load;
    assign diff     = {load_eff[LOAD_W-1], load_eff} - (LOAD_W + 1)'(demand);
    assign detour   = diff[LOAD_W];

    always_comb
    begin
        consume    = 1'b0;
        main_fire  = 1'b0;
        final_fire = 1'b0;
        dist_wr    = 1'b0;
        acc_next   = '0;
        cur_next   = cur_reg;
        load_next  = load_reg;
        addr0      = {cur_eff, dep_idx};
        addr1      = {dep_idx, s1.a_idx};

        if (s1_valid)
        begin
            unique case (s1.op)
                OP_DIST:
                begin
                    dist_wr = s1.a_ok && s1.b_ok;
                    consume = 1'b1;
                end
                OP_DEMAND, OP_NONE:
                begin
                    consume = 1'b1;
                end
                OP_GENE:
                begin
                    if (phase_reg == PH_MAIN)
                    begin
                        main_fire          = 1'b1;
                        consume            = !s1.last;
                        acc_next.valid     = 1'b1;
                        acc_next.reset_sum = !open_reg;
                        if (s1.is_depot)
                        begin
                            cur_next  = dep_idx;
                            load_next = cap_load;
                        end
                        else if (detour)
                        begin
                            acc_next.use1 = 1'b1;
                            cur_next      = s1.a_idx;
                            load_next     = cap_load - LOAD_W'(demand);
                        end
                        else
                        begin
                            addr0     = {cur_eff, s1.a_idx};
                            cur_next  = s1.a_idx;
                            load_next = diff[LOAD_W-1:0];
                        end
                    end
                    else if (emit_ok)
                    begin
                        // Final trip home from the city the gene ended on.
                        final_fire     = 1'b1;
                        consume        = 1'b1;
                        acc_next.valid = 1'b1;
                        acc_next.emit  = 1'b1;
                        addr0          = {cur_reg, dep_idx};
                    end
                end
            endcase
        end
    end

    assign rd_en = main_fire || final_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAIN;
            cur_reg   <= '0;
            load_reg  <= '0;
            open_reg  <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (main_fire)
            begin
                cur_reg  <= cur_next;
                load_reg <= load_next;
                open_reg <= 1'b1;
                if (s1.last)
                begin
                    phase_reg <= PH_FINAL;
                end
            end
            else if (final_fire)
            begin
                open_reg  <= 1'b0;
                phase_reg <= PH_MAIN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dist_wr)
        begin
            dist_mem[{s1.a_idx, s1.b_idx}] <= DIST_BITS'(s1.value);
        end
        if (rd_en)
        begin
            rd0_reg <= dist_mem[addr0];
            rd1_reg <= dist_mem[addr1];
        end
    end

    assign acc = acc_reg;
    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;

endmodule

`default_nettype wire

[hdl/rce_accum.sv]
`default_nettype none

module rce_accum
    import rce_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire acc_t                 acc,
    input  wire logic [DIST_BITS-1:0] rd0,
    input  wire logic [DIST_BITS-1:0] rd1,
    output logic                      emit_ok,
    rce_out_if.source                 result
);

    logic [COST_W-1:0]  cost_reg;
    logic               out_valid_reg;
    logic [COST_W-1:0]  out_cost_reg;
    logic [DIST_BITS:0] step_sum;
    logic [COST_W-1:0]  base;
    logic [COST_W:0]    total;
    logic [COST_W-1:0]  sat;

    // Both legs of a detour are added at once; with non-negative terms this
    // saturates exactly like two separate saturating adds.
    assign step_sum = {1'b0, rd0} + (acc.use1 ? {1'b0, rd1} : '0);
    assign base     = acc.reset_sum ? '0 : cost_reg;
    assign total    = {1'b0, base} + (COST_W + 1)'(step_sum);
    assign sat      = total[COST_W] ? '1 : total[COST_W-1:0];

    // A final read may only go out when the result register will be free
    // by the time its data comes back.
    assign emit_ok = !(acc.valid && acc.emit) && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc.valid)
            begin
                cost_reg <= sat;
            end
            if (acc.valid && acc.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc.valid && acc.emit)
        begin
            out_cost_reg <= sat;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.total_cost = out_cost_reg;

endmodule

`default_nettype wire

[dv/route_cost_checker.sv]
`default_nettype none

// Watches the request and result channels and the register port, keeps its own
// copy of the tables and the open route, and compares every returned cost with
// the oldest predicted one.
module route_cost_checker
    import rce_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    rce_in_if                           item_bus,
    rce_out_if                          result_bus,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          errors,
    output int                          pending,
    output int                          costs_checked
);

    logic [DIST_BITS-1:0] hop_dist [MAX_CITIES*MAX_CITIES];
    logic [VALUE_W-1:0]   city_demand [MAX_CITIES];
    logic [CITY_W-1:0]    depot_reg;
    logic [VALUE_W-1:0]   capacity_reg;
    int                   route_city;
    int                   route_load;
    logic [COST_W-1:0]    route_cost;
    logic                 route_open;
    logic [COST_W-1:0]    expected_costs [$];
    int                   reports;

    function automatic int legal_city(input int c);
        if (c == 0)
            return 1;
        if (c > MAX_CITIES)
            return MAX_CITIES;
        return c;
    endfunction

    function automatic logic in_table(input logic [CITY_W-1:0] c);
        return (c != '0) && (int'(c) <= MAX_CITIES);
    endfunction

    function automatic logic [DIST_BITS-1:0] hop(input int from, input int to);
        return hop_dist[(from - 1) * MAX_CITIES + (to - 1)];
    endfunction

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] s,
                                                  input logic [DIST_BITS-1:0] d);
        longint unsigned t;
        t = longint'(s) + longint'(d);
        if (t > 64'hFFFF_FFFF)
            return '1;
        return t[COST_W-1:0];
    endfunction

    task automatic score_request(input opcode_t op, input logic [CITY_W-1:0] a,
                                 input logic [CITY_W-1:0] b, input logic [VALUE_W-1:0] v,
                                 input logic last);
        int dep;
        int stop;
        int need;
        if (op == OP_DIST)
        begin
            if (in_table(a) && in_table(b))
                hop_dist[(int'(a) - 1) * MAX_CITIES + int'(b) - 1] = v[DIST_BITS-1:0];
            return;
        end
        if (op == OP_DEMAND)
        begin
            if (in_table(a))
                city_demand[int'(a) - 1] = v;
            return;
        end
        if (op != OP_GENE)
            return;

        dep = legal_city(int'(depot_reg));
        if (!route_open)
        begin
            route_city = dep;
            route_load = int'(capacity_reg);
            route_cost = '0;
            route_open = 1'b1;
        end

        if (a == '0)
        begin
            route_cost = sat_add(route_cost, hop(route_city, dep));
            route_load = int'(capacity_reg);
            route_city = dep;
        end
        else
        begin
            stop = legal_city(int'(a));
            need = int'(city_demand[stop - 1]);
            route_load -= need;
            // Not enough load left: go back to the depot, refill, then serve.
            if (route_load < 0)
            begin
                route_cost = sat_add(route_cost, hop(route_city, dep));
                route_cost = sat_add(route_cost, hop(dep, stop));
                route_load = int'(capacity_reg) - need;
            end
            else
            begin
                route_cost = sat_add(route_cost, hop(route_city, stop));
            end
            route_city = stop;
        end

        if (last)
        begin
            route_cost = sat_add(route_cost, hop(route_city, dep));
            expected_costs.insert(expected_costs.size(), route_cost);
            route_open = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depot_reg = 9'd1;
            capacity_reg = 16'd100;
            route_city = 1;
            route_load = 100;
            route_cost = '0;
            route_open = 1'b0;
            expected_costs.delete();
            errors = 0;
            pending = 0;
            costs_checked = 0;
            reports = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_DEPOT)
                    depot_reg = cfg_data[CITY_W-1:0];
                else if (cfg_index == CFG_CAPACITY)
                    capacity_reg = cfg_data[VALUE_W-1:0];
            end
            if (item_bus.valid && item_bus.ready)
                score_request(opcode_t'(item_bus.opcode), item_bus.city_a, item_bus.city_b,
                              item_bus.load_value, item_bus.last_gene);
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_costs.size() == 0)
                begin
                    errors++;
                    if (reports < 10)
                        $display("%0t: cost %0d returned with no route pending",
                                 $time, result_bus.total_cost);
                    reports++;
                end
                else
                begin
                    if (result_bus.total_cost !== expected_costs[0])
                    begin
                        errors++;
                        if (reports < 10)
                            $display("%0t: total_cost mismatch, expected %0d, got %0d",
                                     $time, expected_costs[0], result_bus.total_cost);
                        reports++;
                    end
                    void'(expected_costs.pop_front());
                    costs_checked++;
                end
            end
            pending = expected_costs.size();
        end
    end

endmodule

`default_nettype wire

[dv/vehicle_route_cost_evaluator_test.sv]
`default_nettype none

module vehicle_route_cost_evaluator_test;
    import rce_pkg::*;

    localparam int SINK_HOLD     = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int WORST_GENES   = 100;
    localparam int PHASE_ITEMS   = 200;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rce_in_if  item_bus ();
    rce_out_if result_bus ();

    int errors;
    int expected_left;
    int costs_checked;

    logic [CITY_W-1:0] route_cities [8];
    bit steady = 1'b0;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int requests_sent = 0;
    int genes_sent = 0;
    int routes_sent = 0;
    int settings_used = 0;

    vehicle_route_cost_evaluator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    route_cost_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_bus      (item_bus),
        .result_bus    (result_bus),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (expected_left),
        .costs_checked (costs_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random back-pressure, plus a long hold-off whenever one is asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            result_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_done != holds_asked)
        begin
            result_bus.ready <= 1'b0;
            hold_left <= SINK_HOLD;
            holds_done <= holds_done + 1;
        end
        else
        begin
            result_bus.ready <= steady || ($urandom_range(99) >= 35);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one request and returns at the clock edge that accepts it; valid stays
    // high so that a following request can go out back to back.
    task automatic push_item(input opcode_t op, input logic [CITY_W-1:0] a,
                             input logic [CITY_W-1:0] b, input logic [VALUE_W-1:0] v,
                             input logic last);
        if (!steady)
        begin
            while ($urandom_range(99) < 35)
            begin
                item_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_bus.valid <= 1'b1;
        item_bus.opcode <= op;
        item_bus.city_a <= a;
        item_bus.city_b <= b;
        item_bus.load_value <= v;
        item_bus.last_gene <= last;
        do
            @(posedge clk);
        while (!item_bus.ready);
        requests_sent++;
    endtask

    task automatic send_gene(input logic [CITY_W-1:0] a, input logic last);
        push_item(OP_GENE, a, CITY_W'($urandom_range(511)), VALUE_W'($urandom), last);
        genes_sent++;
        if (last)
            routes_sent++;
    endtask

    // Waits until every predicted cost has come back and the block has gone quiet.
    task automatic settle();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_route_config(input logic [CITY_W-1:0] depot,
                                    input logic [VALUE_W-1:0] capacity);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEPOT;
        cfg_data <= {7'($urandom), depot};
        @(posedge clk);
        cfg_index <= CFG_CAPACITY;
        cfg_data <= capacity;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Fills every distance between the route cities and their demands, so that a
    // route over them never reads an entry that was not loaded.
    task automatic load_tables(input bit worst);
        logic [VALUE_W-1:0] v;
        for (int i = 0; i < 8; i++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                if (worst)
                    v = '1;
                else if ($urandom_range(9) == 0)
                    v = VALUE_W'($urandom);
                else
                    v = VALUE_W'($urandom_range(999));
                push_item(OP_DIST, route_cities[i], route_cities[j], v, 1'($urandom));
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            if (worst)
                v = '1;
            else if (i == 2)
                v = 16'd150;
            else
                v = VALUE_W'($urandom_range(60));
            push_item(OP_DEMAND, route_cities[i], CITY_W'($urandom_range(511)), v,
                      1'($urandom));
        end
    endtask

    function automatic logic [CITY_W-1:0] pick_stop();
        logic [CITY_W-1:0] c;
        if ($urandom_range(99) < 15)
            return '0;
        c = route_cities[$urandom_range(7)];
        // Anything past the last city acts as the last city.
        if (c == CITY_W'(MAX_CITIES) && $urandom_range(1) == 1)
            c = CITY_W'($urandom_range(511, MAX_CITIES + 1));
        return c;
    endfunction

    task automatic send_noise();
        case ($urandom_range(5))
            0: push_item(OP_DIST, CITY_W'($urandom_range(511)), CITY_W'($urandom_range(511)),
                         VALUE_W'($urandom), 1'($urandom));
            1: push_item(OP_DIST, route_cities[$urandom_range(7)],
                         route_cities[$urandom_range(7)], VALUE_W'($urandom), 1'($urandom));
            2: push_item(OP_DEMAND, CITY_W'($urandom_range(511)), CITY_W'($urandom_range(511)),
                         VALUE_W'($urandom), 1'($urandom));
            3: push_item(OP_DEMAND, route_cities[$urandom_range(7)],
                         CITY_W'($urandom_range(511)), VALUE_W'($urandom_range(200)),
                         1'($urandom));
            default: push_item(OP_NONE, CITY_W'($urandom_range(511)),
                               CITY_W'($urandom_range(511)), VALUE_W'($urandom),
                               1'($urandom));
        endcase
    endtask

    task automatic run_route(input int len);
        for (int i = 0; i < len; i++)
        begin
            if (i != 0 && $urandom_range(99) < 5)
                send_noise();
            send_gene(pick_stop(), i == len - 1);
        end
    endtask

    task automatic random_phase(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 80)
            begin
                len = $urandom_range(10, 1);
                run_route(len);
                sent += len;
            end
            else
            begin
                send_noise();
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [CITY_W-1:0] depot;
        logic [VALUE_W-1:0] capacity;

        item_bus.valid = 1'b0;
        item_bus.opcode = OP_DIST;
        item_bus.city_a = '0;
        item_bus.city_b = '0;
        item_bus.load_value = '0;
        item_bus.last_gene = 1'b0;
        result_bus.ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_DEPOT;
        cfg_data = '0;

        route_cities[0] = 9'd1;
        route_cities[1] = CITY_W'(MAX_CITIES);
        for (int k = 0; k < 6; k++)
            route_cities[k + 2] = CITY_W'(3 + 42 * k + $urandom_range(40));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_tables(1'b0);

        // Opening on a depot return, a demand above capacity, a saturated gene city.
        send_gene(9'd0, 1'b0);
        send_gene(route_cities[2], 1'b0);
        send_gene(9'd300, 1'b0);
        send_gene(route_cities[3], 1'b1);
        send_gene(route_cities[4], 1'b1);
        send_gene(9'd0, 1'b1);

        // Out-of-range loads would land on the corner cities if they were not dropped.
        push_item(OP_DIST, 9'd0, CITY_W'(MAX_CITIES), 16'h1234, 1'b0);
        push_item(OP_DIST, 9'd300, 9'd1, 16'h4321, 1'b1);
        push_item(OP_DIST, 9'd1, 9'd0, 16'hFFFF, 1'b0);
        push_item(OP_DIST, CITY_W'(MAX_CITIES), 9'd511, 16'hABCD, 1'b0);
        push_item(OP_DEMAND, 9'd0, 9'd1, 16'hFFFF, 1'b0);
        push_item(OP_DEMAND, 9'd400, 9'd1, 16'hFFFF, 1'b1);
        push_item(OP_NONE, 9'd1, CITY_W'(MAX_CITIES), 16'h7777, 1'b1);
        push_item(OP_DEMAND, route_cities[5], 9'd1, 16'd40, 1'b1);
        send_gene(CITY_W'(MAX_CITIES), 1'b0);
        send_gene(9'd300, 1'b0);
        send_gene(9'd1, 1'b1);

        settle();
        set_route_config(9'd0, 16'd0);
        send_gene(route_cities[3], 1'b0);
        send_gene(9'd0, 1'b0);
        send_gene(route_cities[6], 1'b1);

        settle();
        set_route_config(9'd511, 16'hFFFF);
        send_gene(route_cities[2], 1'b0);
        send_gene(9'd400, 1'b0);
        send_gene(route_cities[7], 1'b1);

        settle();
        set_route_config(CITY_W'(MAX_CITIES), 16'd100);
        send_gene(route_cities[1], 1'b0);
        send_gene(route_cities[5], 1'b0);
        send_gene(9'd0, 1'b1);

        for (int p = 0; p < 7; p++)
        begin
            settle();
            case ($urandom_range(4))
                0: depot = 9'd0;
                1: depot = CITY_W'(MAX_CITIES);
                2: depot = CITY_W'($urandom_range(511, MAX_CITIES + 1));
                default: depot = route_cities[$urandom_range(7)];
            endcase
            case ($urandom_range(4))
                0: capacity = 16'd0;
                1: capacity = 16'hFFFF;
                2: capacity = VALUE_W'($urandom);
                default: capacity = VALUE_W'($urandom_range(300, 20));
            endcase
            set_route_config(depot, capacity);
            steady = (p == 3);
            // The result side stops for a long while; requests keep coming until the
            // block backs up.
            if (p == 5)
                holds_asked++;
            random_phase(PHASE_ITEMS);
            steady = 1'b0;
        end

        // Every leg at its widest and every stop a detour.
        settle();
        set_route_config(9'd1, 16'd0);
        load_tables(1'b1);
        for (int i = 0; i < WORST_GENES; i++)
            send_gene(route_cities[$urandom_range(7)], i == WORST_GENES - 1);

        settle();

        $display("Summary: %0d requests sent, %0d genes over %0d routes, %0d costs checked",
                 requests_sent, genes_sent, routes_sent, costs_checked);
        $display("Summary: %0d depot/capacity settings, closing %0d-gene route of widest legs",
                 settings_used, WORST_GENES);
        if (errors == 0 && expected_left == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
